// ----- rtl/llre_pkg.sv -----
// Package: shared constants, mode codes and helper functions for the LED level engine.
`default_nettype none
package llre_pkg;

    localparam int unsigned CHANNELS     = 5;
    localparam int unsigned LEVEL_W      = 10;
    localparam int unsigned AUDIO_W      = 16;
    localparam int unsigned MODE_W       = 3;
    localparam int unsigned VOL_W        = 3;
    localparam int unsigned STEP_W       = 8;
    localparam int unsigned TARGET_W     = CHANNELS * LEVEL_W;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = TARGET_W;
    localparam int unsigned OUT_DATA_W   = ((TARGET_W + 7) / 8) * 8;
    localparam int unsigned FACTOR_W     = 5;
    localparam int unsigned SUM_W        = AUDIO_W + 1;

    localparam logic [LEVEL_W-1:0] BRIGHT_LIMIT = 10'd1000;

    localparam logic [MODE_W-1:0] MODE_RAMP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MOON  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLOUD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STORM = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOLD  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd3;

    localparam logic [STEP_W-1:0] STEP_RESET = 8'd8;

    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] t_levels;

    function automatic logic [FACTOR_W-1:0] vol_gain(input logic [VOL_W-1:0] vol);
        logic [FACTOR_W-1:0] g;
        case (vol)
            3'd0:    g = 5'd7;
            3'd1:    g = 5'd5;
            3'd2:    g = 5'd3;
            3'd3:    g = 5'd1;
            default: g = 5'd0;
        endcase
        return g;
    endfunction

    function automatic logic [FACTOR_W-1:0] mode_base(input logic [MODE_W-1:0] mode);
        logic [FACTOR_W-1:0] k;
        case (mode)
            MODE_WAVE:  k = 5'd6;
            MODE_CLOUD: k = 5'd16;
            default:    k = 5'd5;
        endcase
        return k;
    endfunction

    function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] base,
                                                   input logic [AUDIO_W-1:0] p);
        logic [SUM_W-1:0] s;
        s = {{(SUM_W-LEVEL_W){1'b0}}, base} + {1'b0, p};
        return (s > {{(SUM_W-LEVEL_W){1'b0}}, BRIGHT_LIMIT}) ? BRIGHT_LIMIT : s[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] sat_sub(input logic [LEVEL_W-1:0] base,
                                                   input logic [AUDIO_W-1:0] p);
        logic [AUDIO_W-1:0] b;
        logic [AUDIO_W-1:0] d;
        b = {{(AUDIO_W-LEVEL_W){1'b0}}, base};
        d = b - p;
        return (b > p) ? d[LEVEL_W-1:0] : '0;
    endfunction

    function automatic logic [LEVEL_W-1:0] track(input logic [LEVEL_W-1:0] cur,
                                                 input logic [LEVEL_W-1:0] sp);
        logic [LEVEL_W-1:0] r;
        if (cur < sp) begin
            r = cur + 1'b1;
        end else if (cur > sp) begin
            r = cur - 1'b1;
        end else begin
            r = cur;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] ramp(input logic [LEVEL_W-1:0] cur,
                                                input logic [LEVEL_W-1:0] tgt,
                                                input logic [STEP_W-1:0] step);
        logic [LEVEL_W:0] up;
        logic [LEVEL_W:0] hi;
        logic [LEVEL_W-1:0] r;
        up = {1'b0, cur} + {3'b000, step};
        hi = {1'b0, tgt} + {3'b000, step};
        if (up < {1'b0, tgt}) begin
            r = up[LEVEL_W-1:0];
        end else if ({1'b0, cur} > hi) begin
            r = cur - {2'b00, step};
        end else begin
            r = tgt;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/led_level_ramp_and_effects_unit.sv -----
// Top level: five-channel LED level engine with ramp and audio-reactive effects.
//
// Usage:
//   Slave stream carries one audio peak-to-peak level per tick. Each accepted
//   transaction yields exactly one master transaction holding the five channel levels
//   after that tick. The user must write configuration (mode, volume, ramp step, targets)
//   through a plain write port only while the engine is idle; not enforced by the block.
// Pipeline and throughput:
//   A transaction is registered in the input register; the level update is
//   one pass of compare/step logic plus a 16x5 product, registered in the level
//   registers. One transaction per cycle is sustained while the receiver does not stall.
// Reset:
//   Synchronous, active low. Levels clear to zero, mode ramp, volume 0,
//   ramp step 8, targets zero; both stages empty.
// Stall:
//   The level registers double as the output register. While the receiver
//   stalls, the result holds, the input register keeps one more transaction,
//   and the slave side then deasserts tready.
`default_nettype none
module led_level_ramp_and_effects_unit
    import llre_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [AUDIO_W-1:0]      i_s_axis_tdata,   // [15:0] audio_level
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,   // [9:0] level_ch0, [19:10] level_ch1,
                                                     // [29:20] level_ch2, [39:30] level_ch3,
                                                     // [49:40] level_ch4, [55:50] zero
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [MODE_W-1:0]   r_mode;
    logic [VOL_W-1:0]    r_vol;
    logic [STEP_W-1:0]   r_step;
    logic [TARGET_W-1:0] r_target;

    logic                r_in_vld;
    logic [AUDIO_W-1:0]  r_audio;
    logic                r_out_vld;
    t_levels             r_level;
    t_levels             n_level;

    logic                w_adv;
    logic [FACTOR_W-1:0] w_factor;
    logic [AUDIO_W+FACTOR_W-1:0] w_prod;
    logic [AUDIO_W-1:0]  w_p;
    t_levels             w_sp;

    assign w_adv           = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-TARGET_W){1'b0}}, r_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RAMP;
            r_vol    <= '0;
            r_step   <= STEP_RESET;
            r_target <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_VOLUME: r_vol    <= i_cfg_data[VOL_W-1:0];
                REG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                REG_TARGET: r_target <= i_cfg_data[TARGET_W-1:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    assign w_factor = mode_base(r_mode) + vol_gain(r_vol);
    assign w_prod   = r_audio * w_factor;
    assign w_p      = w_prod[AUDIO_W-1:0];

    always_comb begin
        w_sp = '0;
        case (r_mode)
            MODE_WAVE: begin
                w_sp[0] = 10'd500;
                w_sp[1] = 10'd500;
                w_sp[2] = 10'd500;
                w_sp[3] = sat_add(10'd200, w_p);
                w_sp[4] = 10'd500;
            end
            MODE_MOON: begin
                w_sp[2] = BRIGHT_LIMIT;
                w_sp[3] = sat_sub(10'd200, w_p);
            end
            MODE_CLOUD: begin
                w_sp[0] = 10'd200;
                w_sp[1] = 10'd200;
                w_sp[2] = sat_add(10'd400, w_p);
                w_sp[3] = sat_sub(10'd320, w_p);
                w_sp[4] = sat_add(10'd400, w_p);
            end
            MODE_STORM: begin
                w_sp[2] = sat_sub(10'd600, w_p);
                w_sp[3] = sat_add(10'd64, w_p);
            end
            default: w_sp = '0;
        endcase
    end

    always_comb begin
        n_level = r_level;
        for (int i = 0; i < CHANNELS; i++) begin
            case (r_mode)
                MODE_RAMP: n_level[i] = ramp(r_level[i], r_target[i*LEVEL_W +: LEVEL_W], r_step);
                MODE_WAVE, MODE_MOON, MODE_CLOUD, MODE_STORM:
                    n_level[i] = track(r_level[i], w_sp[i]);
                default: n_level[i] = r_level[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_level   <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_level   <= n_level;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_audio <= i_s_axis_tdata;
        end
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input side stalled with empty output");

    a_hold_keeps_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_mode == MODE_HOLD)) |=> $stable(r_level))
        else $error("levels moved in hold mode");

    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_in_vld))
        else $error("result appeared without a pending transaction");
`endif

endmodule
`default_nettype wire
